// ===== rtl/tfcm_pkg.sv =====
// Package for the thermal false-colour map: register indexes, palette segment
// codes, fixed widths of the gray path and the palette ramp function.
// No dependencies; imported by temperature_false_color_map.
package tfcm_pkg;

    localparam int QUOT_BITS = 8;
    localparam int LATENCY   = QUOT_BITS + 3;

    localparam logic CFG_LOWER = 1'b0;
    localparam logic CFG_UPPER = 1'b1;

    localparam logic [7:0] GRAY_MIN = 8'h00;
    localparam logic [7:0] GRAY_MAX = 8'hFF;

    typedef enum logic [1:0] {
        SEG_BLUE   = 2'b00,
        SEG_GREEN  = 2'b01,
        SEG_YELLOW = 2'b10,
        SEG_RED    = 2'b11
    } t_segment;

    // floor(k * 255 / 64) for a six-bit k.
    function automatic logic [7:0] ramp(input logic [5:0] k);
        logic [13:0] p;
        p = {k, 8'h00} - 14'(k);
        return p[13:6];
    endfunction

endpackage

// ===== rtl/temperature_false_color_map.sv =====
// Thermal false-colour map: clamps a temperature word between two limits,
// scales it to gray and maps gray to a four-segment palette.
// Depends on tfcm_pkg.
//
//   channel   handshake          payload
//   input     start / busy       i_temperature
//   result    o_valid (strobe)   o_gray, o_red, o_green, o_blue
//   config    i_cfg_we           i_cfg_index, i_cfg_data
//
// One word enters per clock; busy is high only while reset is held. Each result
// is registered through the limit and dividend stages, the eight compare-and-subtract
// stages of the restoring divider and the palette stage.
// Reset clears the valid bits and loads the limits with 2000 and 4000.
// The receiver cannot stall, so the pipeline never holds.
module temperature_false_color_map
    import tfcm_pkg::*;
#(
    parameter int TEMP_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [TEMP_BITS-1:0] i_temperature,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [TEMP_BITS-1:0] i_cfg_data,
    output logic                 o_valid,
    output logic [7:0]           o_gray,
    output logic [7:0]           o_red,
    output logic [7:0]           o_green,
    output logic [7:0]           o_blue
);

    localparam int DW = TEMP_BITS + QUOT_BITS;

    logic signed [TEMP_BITS-1:0] r_lower;
    logic signed [TEMP_BITS-1:0] r_upper;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= TEMP_BITS'(2000);
            r_upper <= TEMP_BITS'(4000);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LOWER: r_lower <= i_cfg_data;
                CFG_UPPER: r_upper <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = !i_rst_n;

    // Limit stage.
    logic signed [TEMP_BITS-1:0] n_temp;
    logic [TEMP_BITS-1:0]        n_num;
    logic [TEMP_BITS-1:0]        n_den;
    logic                        r_v1;
    logic                        r_s0_1;
    logic                        r_s1_1;
    logic [TEMP_BITS-1:0]        r_num_1;
    logic [TEMP_BITS-1:0]        r_den_1;

    assign n_temp = i_temperature;
    assign n_num  = n_temp - r_lower;
    assign n_den  = r_upper - r_lower;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
        end
        r_s0_1  <= n_temp <= r_lower;
        r_s1_1  <= n_temp >= r_upper;
        r_num_1 <= n_num;
        r_den_1 <= n_den;
    end

    // Divider pipeline; index 0 holds the dividend num * 255.
    logic                 r_v   [0:QUOT_BITS];
    logic                 r_s0  [0:QUOT_BITS];
    logic                 r_s1  [0:QUOT_BITS];
    logic [DW-1:0]        r_rem [0:QUOT_BITS];
    logic [QUOT_BITS-1:0] r_q   [0:QUOT_BITS];
    logic [TEMP_BITS-1:0] r_den [0:QUOT_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= r_v1;
        end
        r_s0[0]  <= r_s0_1;
        r_s1[0]  <= r_s1_1;
        r_rem[0] <= {r_num_1, 8'h00} - DW'(r_num_1);
        r_q[0]   <= '0;
        r_den[0] <= r_den_1;
    end

    for (genvar k = 0; k < QUOT_BITS; k++) begin : g_div
        logic [DW-1:0] n_dsh;
        logic [DW:0]   n_diff;
        logic          n_bit;

        assign n_dsh  = DW'(r_den[k]) << (QUOT_BITS - 1 - k);
        assign n_diff = {1'b0, r_rem[k]} - {1'b0, n_dsh};
        assign n_bit  = !n_diff[DW];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
            r_s0[k+1]  <= r_s0[k];
            r_s1[k+1]  <= r_s1[k];
            r_rem[k+1] <= n_bit ? n_diff[DW-1:0] : r_rem[k];
            r_q[k+1]   <= {r_q[k][QUOT_BITS-2:0], n_bit};
            r_den[k+1] <= r_den[k];
        end
    end

    // Palette stage.
    logic [7:0] n_gray;
    logic [7:0] n_red;
    logic [7:0] n_green;
    logic [7:0] n_blue;
    t_segment   n_seg;

    always_comb begin
        if (r_s0[QUOT_BITS]) begin
            n_gray = GRAY_MIN;
        end else if (r_s1[QUOT_BITS]) begin
            n_gray = GRAY_MAX;
        end else begin
            n_gray = r_q[QUOT_BITS];
        end
        n_seg   = t_segment'(n_gray[7:6]);
        n_red   = GRAY_MIN;
        n_green = GRAY_MIN;
        n_blue  = GRAY_MIN;
        case (n_seg)
            SEG_BLUE: begin
                n_blue = ramp(n_gray[5:0]);
            end
            SEG_GREEN: begin
                n_green = ramp(n_gray[5:0]);
                n_blue  = ramp(~n_gray[5:0]);
            end
            SEG_YELLOW: begin
                n_red   = ramp(n_gray[5:0]);
                n_green = GRAY_MAX;
            end
            SEG_RED: begin
                n_red   = GRAY_MAX;
                n_green = ramp(~n_gray[5:0]);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v[QUOT_BITS];
        end
        o_gray  <= n_gray;
        o_red   <= n_red;
        o_green <= n_green;
        o_blue  <= n_blue;
    end

    // Every result traces back to an earlier input word.
    a_result_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("result without a matching input word");

    // Between the limits the quotient must stay below full scale.
    a_quot_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[QUOT_BITS] && !r_s0[QUOT_BITS] && !r_s1[QUOT_BITS])
        |-> (r_q[QUOT_BITS] != GRAY_MAX))
        else $error("unsaturated gray reached full scale");

    // The final remainder must be smaller than the divisor.
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[QUOT_BITS] && !r_s0[QUOT_BITS] && !r_s1[QUOT_BITS])
        |-> (r_rem[QUOT_BITS] < DW'(r_den[QUOT_BITS])))
        else $error("divider remainder not reduced");

    // Gray zero must come out as black.
    a_black_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_gray == GRAY_MIN)
        |-> (o_red == GRAY_MIN && o_green == GRAY_MIN && o_blue == GRAY_MIN))
        else $error("gray zero did not map to black");

endmodule
